// ===== sv/slpe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slpe_pkg
// Shared types, codes and constants of the status pixel pattern engine.
// ----------------------------------------------------------------------------
package slpe_pkg;

    // Pixel row geometry.
    localparam int PIXEL_COUNT = 4;
    localparam int COLOR_W     = 3;
    localparam int PIX_W       = PIXEL_COUNT * COLOR_W;
    localparam int PIX_IDX_W   = $clog2(PIXEL_COUNT);
    localparam int BAR_W       = $clog2(PIXEL_COUNT + 1);

    // Field and state widths.
    localparam int BRIGHT_W = 8;
    localparam int STEP_W   = 16;
    localparam int PERIOD_W = 16;
    localparam int ACT_W    = 3;
    localparam int CMD_W    = 2;
    localparam int CAUSE_W  = 2;

    // Stream bus widths.
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 24;

    // Configuration port.
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_PERIOD = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_START_BRIGHT = 1'b1;

    // Reset values and limits.
    localparam logic [PERIOD_W-1:0] RESET_FRAME_PERIOD = 16'd90;
    localparam logic [BRIGHT_W-1:0] RESET_BRIGHTNESS   = 8'd8;
    localparam logic [PERIOD_W-1:0] ELAPSED_MAX        = 16'hFFFF;

    // Phase counters for the patterns that divide the step count.
    localparam int PH3_W     = 2;
    localparam int PH10_W    = 4;
    localparam logic [PH3_W-1:0]  PH3_LAST  = 2'd2;
    localparam logic [PH10_W-1:0] PH10_LAST = 4'd9;
    localparam logic [PH10_W-1:0] BLINK_ON  = 4'd5;

    // Commands carried on the input tuser.
    typedef enum logic [CMD_W-1:0] {
        CMD_SET_ACTIVITY = 2'd0,
        CMD_TICK         = 2'd1,
        CMD_CYCLE_BRIGHT = 2'd2,
        CMD_SELF_TEST    = 2'd3
    } cmd_t;

    // Activity codes; code seven is stored but has no pattern.
    localparam logic [ACT_W-1:0] ACT_IDLE        = 3'd0;
    localparam logic [ACT_W-1:0] ACT_WIFI_SCAN   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_BLE_SCAN    = 3'd2;
    localparam logic [ACT_W-1:0] ACT_PROMISCUOUS = 3'd3;
    localparam logic [ACT_W-1:0] ACT_OTA         = 3'd4;
    localparam logic [ACT_W-1:0] ACT_PORTAL      = 3'd5;
    localparam logic [ACT_W-1:0] ACT_ERROR       = 3'd6;

    // Frame causes.
    localparam logic [CAUSE_W-1:0] CAUSE_ANIM   = 2'd0;
    localparam logic [CAUSE_W-1:0] CAUSE_BRIGHT = 2'd1;
    localparam logic [CAUSE_W-1:0] CAUSE_TEST   = 2'd2;

    // Pixel colors: bit 2 red, bit 1 green, bit 0 blue.
    localparam logic [COLOR_W-1:0] COL_OFF     = 3'd0;
    localparam logic [COLOR_W-1:0] COL_BLUE    = 3'd1;
    localparam logic [COLOR_W-1:0] COL_GREEN   = 3'd2;
    localparam logic [COLOR_W-1:0] COL_RED     = 3'd4;
    localparam logic [COLOR_W-1:0] COL_MAGENTA = 3'd5;
    localparam logic [COLOR_W-1:0] COL_YELLOW  = 3'd6;
    localparam logic [COLOR_W-1:0] COL_WHITE   = 3'd7;

    // State handed to the pattern decoder.
    typedef struct packed {
        logic [ACT_W-1:0]     activity;
        logic [PIX_IDX_W-1:0] step_low;
        logic [BAR_W-1:0]     bar_lit;
        logic                 blink_on;
    } pat_state_t;

    // One result beat.
    typedef struct packed {
        logic [PIX_W-1:0]    pixel_colors;
        logic [BRIGHT_W-1:0] brightness;
        logic [CAUSE_W-1:0]  cause;
    } result_t;

    // Brightness ladder 0, 2, 3, 5, 8, 12; an off-ladder level steps to 2.
    function automatic logic [BRIGHT_W-1:0] next_level(input logic [BRIGHT_W-1:0] level);
        logic [BRIGHT_W-1:0] nxt;
        case (level)
            8'd2:    nxt = 8'd3;
            8'd3:    nxt = 8'd5;
            8'd5:    nxt = 8'd8;
            8'd8:    nxt = 8'd12;
            8'd12:   nxt = 8'd0;
            default: nxt = 8'd2;
        endcase
        return nxt;
    endfunction

    // Self-test frame: red, green, blue, yellow repeating along the row.
    function automatic logic [PIX_W-1:0] self_test_colors();
        logic [PIX_W-1:0] acc;
        acc = '0;
        for (int i = 0; i < PIXEL_COUNT; i++) begin
            case (i % 4)
                0:       acc[i*COLOR_W +: COLOR_W] = COL_RED;
                1:       acc[i*COLOR_W +: COLOR_W] = COL_GREEN;
                2:       acc[i*COLOR_W +: COLOR_W] = COL_BLUE;
                default: acc[i*COLOR_W +: COLOR_W] = COL_YELLOW;
            endcase
        end
        return acc;
    endfunction

    localparam logic [PIX_W-1:0] SELF_TEST_PIX = self_test_colors();

endpackage

// ===== sv/slpe_pattern.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slpe_pattern
// Decodes activity and step phase into the colors of the pixel row.
// ----------------------------------------------------------------------------
module slpe_pattern (
    input  slpe_pkg::pat_state_t            st,
    output logic [slpe_pkg::PIX_W-1:0]      pixel_colors
);
    import slpe_pkg::*;

    // One color per pixel, chosen by the activity.
    always_comb begin
        pixel_colors = '0;
        for (int i = 0; i < PIXEL_COUNT; i++) begin
            unique case (st.activity)
                ACT_WIFI_SCAN: begin
                    if (PIX_IDX_W'(i) == st.step_low) begin
                        pixel_colors[i*COLOR_W +: COLOR_W] = COL_GREEN;
                    end
                end
                ACT_BLE_SCAN: begin
                    if (st.blink_on) begin
                        pixel_colors[i*COLOR_W +: COLOR_W] = COL_BLUE;
                    end
                end
                ACT_PROMISCUOUS: begin
                    // Lit where pixel index and step have the same parity.
                    if ((i % 2) == int'(st.step_low[0])) begin
                        pixel_colors[i*COLOR_W +: COLOR_W] = COL_YELLOW;
                    end
                end
                ACT_OTA: begin
                    if (i < int'(st.bar_lit)) begin
                        pixel_colors[i*COLOR_W +: COLOR_W] = COL_WHITE;
                    end
                end
                ACT_PORTAL: begin
                    pixel_colors[i*COLOR_W +: COLOR_W] = COL_MAGENTA;
                end
                ACT_ERROR: begin
                    if (st.step_low[0]) begin
                        pixel_colors[i*COLOR_W +: COLOR_W] = COL_RED;
                    end
                end
                default: begin
                    pixel_colors[i*COLOR_W +: COLOR_W] = COL_OFF;
                end
            endcase
        end
    end

endmodule

// ===== sv/slpe_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slpe_ctrl
// Holds activity, step, timing and brightness state, executes one command
// per beat and forms the result beat.
// ----------------------------------------------------------------------------
module slpe_ctrl (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             fire,
    input  slpe_pkg::cmd_t                   cmd,
    input  logic [slpe_pkg::ACT_W-1:0]       act,
    input  logic                             cfg_we,
    input  logic [slpe_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [slpe_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output logic                             has_result,
    output slpe_pkg::result_t                result
);
    import slpe_pkg::*;

    logic [ACT_W-1:0]    activity_reg, activity_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [PERIOD_W-1:0] elapsed_reg, elapsed_next;
    logic [BRIGHT_W-1:0] live_reg, live_next;
    logic [PERIOD_W-1:0] period_reg;
    logic [BRIGHT_W-1:0] start_reg;
    logic [PH3_W-1:0]    ph3_reg, ph3_next;
    logic [BAR_W-1:0]    bar_reg, bar_next;
    logic [PH10_W-1:0]   ph10_reg, ph10_next;

    logic [PERIOD_W-1:0] elapsed_inc;
    logic [STEP_W-1:0]   step_adv;
    logic                paint;
    logic                blank_bright;
    pat_state_t          pat_st;
    logic [PIX_W-1:0]    pat_pix;

    // Command execution: next state and which kind of beat goes out.
    always_comb begin
        activity_next = activity_reg;
        step_next     = step_reg;
        elapsed_next  = elapsed_reg;
        live_next     = live_reg;
        ph3_next      = ph3_reg;
        bar_next      = bar_reg;
        ph10_next     = ph10_reg;
        paint         = 1'b0;
        blank_bright  = 1'b0;
        elapsed_inc   = (elapsed_reg == ELAPSED_MAX) ? elapsed_reg
                                                     : PERIOD_W'(elapsed_reg + 1'b1);
        step_adv      = STEP_W'(step_reg + 1'b1);

        unique case (cmd)
            CMD_SET_ACTIVITY: begin
                if (act != activity_reg) begin
                    activity_next = act;
                    step_next     = '0;
                    ph3_next      = '0;
                    bar_next      = '0;
                    ph10_next     = '0;
                    paint         = (live_reg != '0);
                end
            end
            CMD_TICK: begin
                elapsed_next = elapsed_inc;
                if ((live_reg != '0) && (activity_reg != ACT_IDLE) &&
                    (elapsed_inc >= period_reg)) begin
                    step_next = step_adv;
                    paint     = 1'b1;
                    // The phase counters restart with the step count when it wraps.
                    if (step_adv == '0) begin
                        ph3_next  = '0;
                        bar_next  = '0;
                        ph10_next = '0;
                    end else begin
                        ph3_next  = (ph3_reg == PH3_LAST) ? '0 : PH3_W'(ph3_reg + 1'b1);
                        if (ph3_reg == PH3_LAST) begin
                            bar_next = (bar_reg == BAR_W'(PIXEL_COUNT)) ? '0
                                                                        : BAR_W'(bar_reg + 1'b1);
                        end
                        ph10_next = (ph10_reg == PH10_LAST) ? '0 : PH10_W'(ph10_reg + 1'b1);
                    end
                end
            end
            CMD_CYCLE_BRIGHT: begin
                live_next = next_level(live_reg);
                if (live_next != '0) begin
                    paint = 1'b1;
                end else begin
                    blank_bright = 1'b1;
                end
            end
            CMD_SELF_TEST: begin
                // Timing state is left alone.
            end
        endcase

        // A painted frame restarts the frame timer.
        if (paint) begin
            elapsed_next = '0;
        end
    end

    // The pattern is drawn from the state after this command.
    assign pat_st.activity = activity_next;
    assign pat_st.step_low = step_next[PIX_IDX_W-1:0];
    assign pat_st.bar_lit  = bar_next;
    assign pat_st.blink_on = (ph10_next < BLINK_ON);

    slpe_pattern u_pattern (
        .st           (pat_st),
        .pixel_colors (pat_pix)
    );

    // Result beat assembly.
    always_comb begin
        has_result          = 1'b0;
        result.pixel_colors = pat_pix;
        result.brightness   = live_next;
        result.cause        = CAUSE_ANIM;
        if (cmd == CMD_SELF_TEST) begin
            has_result          = 1'b1;
            result.pixel_colors = SELF_TEST_PIX;
            result.brightness   = (live_reg != '0) ? live_reg : start_reg;
            result.cause        = CAUSE_TEST;
        end else if (blank_bright) begin
            has_result          = 1'b1;
            result.pixel_colors = '0;
            result.brightness   = '0;
            result.cause        = CAUSE_BRIGHT;
        end else if (paint) begin
            has_result   = 1'b1;
            result.cause = (cmd == CMD_CYCLE_BRIGHT) ? CAUSE_BRIGHT : CAUSE_ANIM;
        end
    end

    // State registers; a configuration write takes priority.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            activity_reg <= ACT_IDLE;
            step_reg     <= '0;
            elapsed_reg  <= '0;
            live_reg     <= RESET_BRIGHTNESS;
            period_reg   <= RESET_FRAME_PERIOD;
            start_reg    <= RESET_BRIGHTNESS;
            ph3_reg      <= '0;
            bar_reg      <= '0;
            ph10_reg     <= '0;
        end else begin
            if (fire) begin
                activity_reg <= activity_next;
                step_reg     <= step_next;
                elapsed_reg  <= elapsed_next;
                live_reg     <= live_next;
                ph3_reg      <= ph3_next;
                bar_reg      <= bar_next;
                ph10_reg     <= ph10_next;
            end
            if (cfg_we) begin
                unique case (cfg_addr)
                    REG_FRAME_PERIOD: begin
                        period_reg <= cfg_wdata;
                    end
                    REG_START_BRIGHT: begin
                        start_reg <= cfg_wdata[BRIGHT_W-1:0];
                        live_reg  <= cfg_wdata[BRIGHT_W-1:0];
                    end
                endcase
            end
        end
    end

endmodule

// ===== sv/status_led_pattern_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// status_led_pattern_engine
// Command-driven pattern engine for a row of four pure-color status pixels.
//
//   Port group | Dir | Carries
//   -----------+-----+-------------------------------------------------------
//   s_t*       | in  | tuser: command; tdata: activity
//   m_t*       | out | tdata: pixel_colors, brightness; tuser: cause
//   cfg_*      | in  | register writes: frame_period_ms, start_brightness
//
// One beat per cycle sustained while m_tready stays high. A command is held
// in the input register, is executed by the control logic and lands in the
// output register, from which its result is offered on the output channel.
// Commands that produce no frame leave nothing on the output channel.
// A stall on m_tready holds the output register and then the input register.
// Reset (aresetn low, synchronous) clears the valid flags and restores engine state and register defaults.
// ----------------------------------------------------------------------------
module status_led_pattern_engine (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // Input channel.
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [slpe_pkg::S_TDATA_W-1:0]       s_tdata,  // [2:0] activity
    input  logic [slpe_pkg::CMD_W-1:0]           s_tuser,  // [1:0] command
    // Result channel.
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [slpe_pkg::M_TDATA_W-1:0]       m_tdata,  // [11:0] pixel_colors,
                                                           // [19:12] brightness
    output logic [slpe_pkg::CAUSE_W-1:0]         m_tuser,  // [1:0] cause
    // Configuration writes.
    input  logic                                 cfg_we,
    input  logic [slpe_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [slpe_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
    import slpe_pkg::*;

    logic             in_valid_reg;
    cmd_t             in_cmd_reg;
    logic [ACT_W-1:0] in_act_reg;
    logic             out_valid_reg;
    result_t          out_data_reg;

    logic             out_free;
    logic             fire;
    logic             has_result;
    result_t          result;

    // Handshake: the input stage moves whenever the output register can take.
    assign out_free = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_cmd_reg <= cmd_t'(s_tuser);
            in_act_reg <= s_tdata[ACT_W-1:0];
        end
    end

    slpe_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fire       (fire),
        .cmd        (in_cmd_reg),
        .act        (in_act_reg),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .has_result (has_result),
        .result     (result)
    );

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= fire && has_result;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && has_result) begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_TDATA_W - PIX_W - BRIGHT_W)'(0),
                       out_data_reg.brightness, out_data_reg.pixel_colors};
    assign m_tuser  = out_data_reg.cause;

`ifndef SYNTHESIS
    // Animation frames only go out while the live brightness is nonzero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == CAUSE_ANIM)) |-> (m_tdata[PIX_W +: BRIGHT_W] != '0))
        else $error("animation frame with zero brightness");

    // A self-test frame always carries the fixed test colors.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == CAUSE_TEST)) |-> (m_tdata[PIX_W-1:0] == SELF_TEST_PIX))
        else $error("self-test frame with wrong colors");

    // A brightness frame at level zero is blank.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == CAUSE_BRIGHT) && (m_tdata[PIX_W +: BRIGHT_W] == '0))
        |-> (m_tdata[PIX_W-1:0] == '0))
        else $error("zero-brightness frame is not blank");

    // An executed self-test command always produces a beat in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && (in_cmd_reg == CMD_SELF_TEST)) |=> (m_tvalid && (m_tuser == CAUSE_TEST)))
        else $error("self-test command lost");
`endif

endmodule

// ===== sim/tb_status_led_pattern_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_status_led_pattern_engine
// Self-checking bench for the status pixel pattern engine.
//
// Commands are queued by the stimulus process and presented by a driver
// that idles at random. The monitor predicts each accepted command with its
// own copy of the engine state and checks every output frame in order.
// The run covers two short directed sequences and randomized phases under
// several register settings.
// ----------------------------------------------------------------------------
module tb_status_led_pattern_engine;

    import slpe_pkg::*;

    // Result latency after acceptance, and settle time before register writes.
    localparam int PIPE_LAT     = 2;
    localparam int SETTLE_LAT   = PIPE_LAT + 6;
    localparam int PHASE_ITEMS  = 88;
    localparam int REPORT_LIMIT = 10;

    // Brightness ladder, lowest entry in the lowest byte.
    localparam logic [6*BRIGHT_W-1:0] LADDER = {8'd12, 8'd8, 8'd5, 8'd3, 8'd2, 8'd0};

    // One queued command.
    typedef struct packed {
        cmd_t             cmd;
        logic [ACT_W-1:0] act;
    } led_cmd_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;   // [2:0] activity
    logic [CMD_W-1:0]      s_tuser   = '0;   // [1:0] command
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;          // [11:0] pixel_colors, [19:12] brightness
    logic [CAUSE_W-1:0]    m_tuser;          // [1:0] cause
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Shadow copy of the engine state and registers.
    logic [PERIOD_W-1:0] period_ms;
    logic [BRIGHT_W-1:0] start_lvl;
    logic [BRIGHT_W-1:0] live_lvl;
    logic [ACT_W-1:0]    act_now;
    logic [STEP_W-1:0]   step_no;
    logic [PERIOD_W-1:0] since_paint;

    led_cmd_t pending_cmds[$];
    result_t  frames_due[$];

    int idle_pct       = 30;
    int cmds_accepted  = 0;
    int shown_idx      = -1;
    int frames_checked = 0;
    int fail_count     = 0;

    status_led_pattern_engine dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Pixel row for an activity at a given step.
    function automatic logic [PIX_W-1:0] pattern_of(input logic [ACT_W-1:0] act,
                                                    input logic [STEP_W-1:0] at_step);
        logic [PIX_W-1:0] acc;
        int s;
        int lit;
        acc = '0;
        s   = at_step;
        lit = (s / 3) % (PIXEL_COUNT + 1);
        for (int i = 0; i < PIXEL_COUNT; i++) begin
            case (act)
                ACT_WIFI_SCAN:   if (i == s % PIXEL_COUNT) acc[i*COLOR_W +: COLOR_W] = COL_GREEN;
                ACT_BLE_SCAN:    if ((s / 5) % 2 == 0) acc[i*COLOR_W +: COLOR_W] = COL_BLUE;
                ACT_PROMISCUOUS: if ((i + s) % 2 == 0) acc[i*COLOR_W +: COLOR_W] = COL_YELLOW;
                ACT_OTA:         if (i < lit) acc[i*COLOR_W +: COLOR_W] = COL_WHITE;
                ACT_PORTAL:      acc[i*COLOR_W +: COLOR_W] = COL_MAGENTA;
                ACT_ERROR:       if (s % 2 == 1) acc[i*COLOR_W +: COLOR_W] = COL_RED;
                default:         ;
            endcase
        end
        return acc;
    endfunction

    // Next brightness on the ladder; an off-ladder level behaves like zero.
    function automatic logic [BRIGHT_W-1:0] ladder_next(input logic [BRIGHT_W-1:0] lvl);
        int idx;
        idx = 0;
        for (int i = 5; i >= 0; i--)
            if (LADDER[i*BRIGHT_W +: BRIGHT_W] == lvl) idx = i;
        return LADDER[((idx + 1) % 6)*BRIGHT_W +: BRIGHT_W];
    endfunction

    // Apply one command to the shadow state; returns 1 when a frame is due.
    function automatic bit frame_for_command(input cmd_t cmd, input logic [ACT_W-1:0] act,
                                             output result_t fr);
        bit                 repaint;
        logic [CAUSE_W-1:0] why;
        repaint = 1'b0;
        why     = CAUSE_ANIM;
        fr      = '0;
        case (cmd)
            CMD_SET_ACTIVITY: begin
                if (act == act_now) return 1'b0;
                act_now = act;
                step_no = '0;
                repaint = (live_lvl != 0);
            end
            CMD_TICK: begin
                if (since_paint != ELAPSED_MAX) since_paint++;
                if (live_lvl != 0 && act_now != ACT_IDLE && since_paint >= period_ms) begin
                    step_no++;
                    repaint = 1'b1;
                end
            end
            CMD_CYCLE_BRIGHT: begin
                live_lvl = ladder_next(live_lvl);
                why      = CAUSE_BRIGHT;
                // Dimming to zero shows a blank frame without touching the timer.
                if (live_lvl == 0) begin
                    fr.cause = CAUSE_BRIGHT;
                    return 1'b1;
                end
                repaint = 1'b1;
            end
            default: begin
                for (int i = 0; i < PIXEL_COUNT; i++) begin
                    case (i % 4)
                        0:       fr.pixel_colors[i*COLOR_W +: COLOR_W] = COL_RED;
                        1:       fr.pixel_colors[i*COLOR_W +: COLOR_W] = COL_GREEN;
                        2:       fr.pixel_colors[i*COLOR_W +: COLOR_W] = COL_BLUE;
                        default: fr.pixel_colors[i*COLOR_W +: COLOR_W] = COL_YELLOW;
                    endcase
                end
                fr.brightness = (live_lvl != 0) ? live_lvl : start_lvl;
                fr.cause      = CAUSE_TEST;
                return 1'b1;
            end
        endcase
        if (repaint) begin
            since_paint     = '0;
            fr.pixel_colors = pattern_of(act_now, step_no);
            fr.brightness   = live_lvl;
            fr.cause        = why;
        end
        return repaint;
    endfunction

    // Driver: present queued commands and toggle the result-side ready.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= idle_pct);
        if (!(s_tvalid && cmds_accepted == shown_idx)) begin
            if (aresetn && pending_cmds.size() != 0 && $urandom_range(99) >= idle_pct) begin
                s_tvalid  <= 1'b1;
                s_tuser   <= pending_cmds[0].cmd;
                s_tdata   <= {{(S_TDATA_W-ACT_W){1'b0}}, pending_cmds[0].act};
                shown_idx = cmds_accepted;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: check frames in order, then predict the accepted command.
    always @(posedge aclk) begin
        result_t want;
        result_t pred;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (frames_due.size() == 0) begin
                    if (fail_count < REPORT_LIMIT)
                        $display("MISMATCH at %0t: unexpected frame pix=%h bright=%0d cause=%0d",
                                 $realtime, m_tdata[PIX_W-1:0], m_tdata[PIX_W +: BRIGHT_W],
                                 m_tuser);
                    fail_count++;
                end else begin
                    want = frames_due.pop_front();
                    frames_checked++;
                    if (m_tdata[PIX_W-1:0] !== want.pixel_colors ||
                        m_tdata[PIX_W +: BRIGHT_W] !== want.brightness ||
                        m_tuser !== want.cause) begin
                        if (fail_count < REPORT_LIMIT)
                            $display("MISMATCH at %0t: pix %h/%h bright %0d/%0d cause %0d/%0d",
                                     $realtime, m_tdata[PIX_W-1:0], want.pixel_colors,
                                     m_tdata[PIX_W +: BRIGHT_W], want.brightness,
                                     m_tuser, want.cause);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                if (frame_for_command(cmd_t'(s_tuser), s_tdata[ACT_W-1:0], pred))
                    frames_due.push_back(pred);
                void'(pending_cmds.pop_front());
                cmds_accepted++;
            end
        end
    end

    task automatic queue_cmd(input cmd_t cmd, input logic [ACT_W-1:0] act);
        led_cmd_t c;
        c.cmd = cmd;
        c.act = act;
        pending_cmds.push_back(c);
    endtask

    // Wait until every command is taken and every frame has come, then settle.
    task automatic drain_engine();
        while (pending_cmds.size() != 0 || frames_due.size() != 0) @(negedge aclk);
        repeat (SETTLE_LAT) @(negedge aclk);
    endtask

    // Register write; the shadow copy follows the same rules as the engine.
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input int value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value[CFG_DATA_W-1:0];
        if (addr == REG_FRAME_PERIOD) begin
            period_ms = value[PERIOD_W-1:0];
        end else begin
            start_lvl = value[BRIGHT_W-1:0];
            live_lvl  = value[BRIGHT_W-1:0];
        end
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // About half ticks so the animations advance, mixed with the other commands.
    task automatic queue_random(input int count);
        int r;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(99);
            if (r < 50)      queue_cmd(CMD_TICK, ACT_W'($urandom_range(7)));
            else if (r < 68) queue_cmd(CMD_SET_ACTIVITY, ACT_W'($urandom_range(7)));
            else if (r < 84) queue_cmd(CMD_CYCLE_BRIGHT, ACT_W'($urandom_range(7)));
            else             queue_cmd(CMD_SELF_TEST, ACT_W'($urandom_range(7)));
        end
    endtask

    // Stimulus sequence.
    initial begin
        int per;
        int lvl;
        period_ms   = RESET_FRAME_PERIOD;
        start_lvl   = RESET_BRIGHTNESS;
        live_lvl    = RESET_BRIGHTNESS;
        act_now     = ACT_IDLE;
        step_no     = '0;
        since_paint = '0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part under reset settings: repeats, full brightness ladder,
        // an activity without a pattern.
        queue_cmd(CMD_SELF_TEST, ACT_IDLE);
        queue_cmd(CMD_SET_ACTIVITY, ACT_IDLE);
        queue_cmd(CMD_SET_ACTIVITY, ACT_WIFI_SCAN);
        queue_cmd(CMD_SET_ACTIVITY, ACT_WIFI_SCAN);
        repeat (6) queue_cmd(CMD_CYCLE_BRIGHT, ACT_IDLE);
        queue_cmd(CMD_SET_ACTIVITY, 3'd7);
        queue_cmd(CMD_TICK, 3'd7);
        drain_engine();

        // Directed part with zero brightness and a period of one.
        write_reg(REG_FRAME_PERIOD, 1);
        write_reg(REG_START_BRIGHT, 0);
        queue_cmd(CMD_SELF_TEST, ACT_IDLE);
        queue_cmd(CMD_SET_ACTIVITY, ACT_PROMISCUOUS);
        queue_cmd(CMD_TICK, ACT_IDLE);
        queue_cmd(CMD_CYCLE_BRIGHT, ACT_IDLE);
        queue_cmd(CMD_SET_ACTIVITY, ACT_BLE_SCAN);
        queue_cmd(CMD_TICK, ACT_IDLE);
        queue_cmd(CMD_SET_ACTIVITY, ACT_OTA);
        queue_cmd(CMD_TICK, ACT_IDLE);
        queue_cmd(CMD_SET_ACTIVITY, ACT_PORTAL);
        queue_cmd(CMD_SET_ACTIVITY, ACT_ERROR);
        queue_cmd(CMD_TICK, ACT_IDLE);
        queue_cmd(CMD_TICK, ACT_IDLE);
        queue_cmd(CMD_SET_ACTIVITY, ACT_IDLE);
        queue_cmd(CMD_TICK, ACT_IDLE);
        drain_engine();

        // Randomized phases, each under its own register setting.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0:       begin per = 1;     lvl = 2;   end
                1:       begin per = 0;     lvl = 255; end
                2:       begin per = 4;     lvl = 12;  end
                3:       begin per = 65535; lvl = 8;   end
                4:       begin per = $urandom_range(7, 2); lvl = $urandom_range(255); end
                default: begin per = 2;     lvl = 0;   end
            endcase
            idle_pct = (ph == 1) ? 0 : 30;
            write_reg(REG_FRAME_PERIOD, per);
            write_reg(REG_START_BRIGHT, lvl);
            queue_random(PHASE_ITEMS);
            drain_engine();
        end

        $display("Covered %0d commands and %0d checked frames across directed sequences",
                 cmds_accepted, frames_checked);
        $display("and six randomized register settings; %0d mismatches.", fail_count);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #20ms;
        $display("simulation failed");
        $finish;
    end

endmodule
